>>> hw/rtl/bltb_pkg.sv
// Shared constants, codes and helpers of the bounded line tail buffer.
package bltb_pkg;

  // Default sizes of the stores
  localparam int MAX_BYTES_DEF      = 16384;
  localparam int MAX_LINES_DEF      = 256;
  localparam int MAX_LINE_BYTES_DEF = 1024;

  // Fixed field widths of the channels and the configuration port
  localparam int FUNC_W     = 2;
  localparam int BYTE_W     = 8;
  localparam int INDEX_W    = 14;
  localparam int LEN_W      = 11;
  localparam int LCNT_W     = 9;
  localparam int BCNT_W     = 15;
  localparam int REV_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // Register reset values
  localparam logic [LEN_W-1:0]  RST_MAX_LINE_LEN = 11'd1024;
  localparam logic [LCNT_W-1:0] RST_MAX_LINES    = 9'd256;
  localparam logic [BCNT_W-1:0] RST_MAX_BYTES    = 15'd16384;

  localparam logic [BYTE_W-1:0] NL_CHAR = 8'h0A;
  localparam logic [BYTE_W-1:0] CR_CHAR = 8'h0D;

  typedef enum logic [FUNC_W-1:0] {
    FN_CONSUME   = 2'd0,
    FN_CLEAR     = 2'd1,
    FN_READ_BYTE = 2'd2,
    FN_READ_LEN  = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_LINE_LEN = 2'd0,
    CFG_MAX_LINES    = 2'd1,
    CFG_MAX_BYTES    = 2'd2
  } cfg_reg_t;

  // Add two offsets inside a ring of m entries; a must be below m and b at most m.
  function automatic logic [31:0] ring_add(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] m);
    logic [31:0] s;
    s = a + b;
    return (s >= m) ? s - m : s;
  endfunction

endpackage

>>> hw/rtl/bltb_in_if.sv
// Input channel: one function request per transfer.
interface bltb_in_if import bltb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [BYTE_W-1:0]  data_byte;
  logic [INDEX_W-1:0] index;

  modport source (output valid, func, data_byte, index, input ready);
  modport sink   (input valid, func, data_byte, index, output ready);
endinterface

>>> hw/rtl/bltb_out_if.sv
// Result channel: one status and read result per transfer.
interface bltb_out_if import bltb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              line_committed;
  logic [LEN_W-1:0]  committed_length;
  logic [LCNT_W-1:0] evicted_lines;
  logic [LCNT_W-1:0] line_count;
  logic [BCNT_W-1:0] retained_bytes;
  logic [LEN_W-1:0]  tail_length;
  logic              discarding;
  logic [REV_W-1:0]  revision;
  logic [LEN_W-1:0]  read_data;
  logic              read_valid;

  modport source (output valid, line_committed, committed_length, evicted_lines, line_count,
                  retained_bytes, tail_length, discarding, revision, read_data, read_valid,
                  input ready);
  modport sink   (input valid, line_committed, committed_length, evicted_lines, line_count,
                  retained_bytes, tail_length, discarding, revision, read_data, read_valid,
                  output ready);
endinterface

>>> hw/rtl/bltb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bltb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/bltb_limits.sv
// Configuration registers and the effective limits derived from them.
module bltb_limits import bltb_pkg::*; #(
  parameter int MAX_BYTES      = MAX_BYTES_DEF,
  parameter int MAX_LINES      = MAX_LINES_DEF,
  parameter int MAX_LINE_BYTES = MAX_LINE_BYTES_DEF,
  localparam int BC_W = $clog2(MAX_BYTES + 1),
  localparam int LC_W = $clog2(MAX_LINES + 1),
  localparam int LL_W = $clog2(MAX_LINE_BYTES + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic [LL_W-1:0]       eff_line_len,
  output logic [LC_W-1:0]       eff_lines,
  output logic [BC_W-1:0]       eff_bytes
);

  logic [LEN_W-1:0]  max_line_len_r;
  logic [LCNT_W-1:0] max_lines_r;
  logic [BCNT_W-1:0] max_bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_line_len_r <= RST_MAX_LINE_LEN;
      max_lines_r    <= RST_MAX_LINES;
      max_bytes_r    <= RST_MAX_BYTES;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_LINE_LEN: max_line_len_r <= cfg_wdata[LEN_W-1:0];
        CFG_MAX_LINES:    max_lines_r    <= cfg_wdata[LCNT_W-1:0];
        CFG_MAX_BYTES:    max_bytes_r    <= cfg_wdata[BCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp each register to [1, store size]; the line length limit also obeys the byte limit.
  always_comb begin
    logic [31:0] lines_c;
    logic [31:0] bytes_c;
    logic [31:0] len_c;
    lines_c = 32'(max_lines_r);
    bytes_c = 32'(max_bytes_r);
    len_c   = 32'(max_line_len_r);
    if (lines_c == 32'd0) lines_c = 32'd1;
    else if (lines_c > 32'(MAX_LINES)) lines_c = 32'(MAX_LINES);
    if (bytes_c == 32'd0) bytes_c = 32'd1;
    else if (bytes_c > 32'(MAX_BYTES)) bytes_c = 32'(MAX_BYTES);
    if (len_c == 32'd0) len_c = 32'd1;
    else if (len_c > 32'(MAX_LINE_BYTES)) len_c = 32'(MAX_LINE_BYTES);
    if (len_c > bytes_c) len_c = bytes_c;
    eff_lines    = LC_W'(lines_c);
    eff_bytes    = BC_W'(bytes_c);
    eff_line_len = LL_W'(len_c);
  end

endmodule

>>> hw/rtl/bounded_line_tail_buffer_core.sv
// Line splitter keeping the newest lines of a byte stream in a byte ring and a length queue.
// Sequence: an accepted item goes from IDLE to DECIDE, which loads the result register unless
//   it is still held (then RESP waits); each evicted line passes EV_RD (length queue read) and
//   EV_UP (pointer update), a newline into a full queue passes COMMIT. Items are taken in IDLE only.
// Reset: synchronous, active low; clears pointers, counters, revision and the registers to
//   their defaults. The memories are not swept: only written entries are ever used.
module bounded_line_tail_buffer_core import bltb_pkg::*; #(
  parameter int MAX_BYTES      = MAX_BYTES_DEF,
  parameter int MAX_LINES      = MAX_LINES_DEF,
  parameter int MAX_LINE_BYTES = MAX_LINE_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bltb_in_if.sink               in_ch,
  bltb_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int BA_W = $clog2(MAX_BYTES);
  localparam int BC_W = $clog2(MAX_BYTES + 1);
  localparam int LA_W = $clog2(MAX_LINES);
  localparam int LC_W = $clog2(MAX_LINES + 1);
  localparam int LL_W = $clog2(MAX_LINE_BYTES + 1);
  localparam int RD_W = (LL_W > BYTE_W) ? LL_W : BYTE_W;

  // Sequencer states:
  //   IDLE    take an item and issue the memory reads it needs
  //   DECIDE  act on the read data; a newline into a full queue evicts first
  //   COMMIT  finish that newline after the forced eviction
  //   EV_RD   read the oldest line length
  //   EV_UP   drop the oldest line and test the limits again
  //   RESP    hold a finished result until the output register frees up
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECIDE = 6'b000010,
    ST_COMMIT = 6'b000100,
    ST_EV_RD  = 6'b001000,
    ST_EV_UP  = 6'b010000,
    ST_RESP   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Buffer state
  logic [BA_W-1:0]  byte_head_r, byte_head_nxt;
  logic [LA_W-1:0]  line_head_r, line_head_nxt;
  logic [LC_W-1:0]  lines_r, lines_nxt;
  logic [BC_W-1:0]  bytes_r, bytes_nxt;
  logic [LL_W-1:0]  tail_r, tail_nxt;
  logic             skip_r, skip_nxt;
  logic [REV_W-1:0] rev_r, rev_nxt;

  // Item under work
  logic [FUNC_W-1:0]  func_r;
  logic [BYTE_W-1:0]  data_r;
  logic [INDEX_W-1:0] idx_r;

  // Per-item results
  logic            commit_r, commit_nxt;
  logic [LL_W-1:0] clen_r, clen_nxt;
  logic [LC_W-1:0] evcnt_r, evcnt_nxt;
  logic [RD_W-1:0] rdata_r, rdata_nxt;
  logic            rvalid_r, rvalid_nxt;

  // Output register
  logic              out_valid_r;
  logic              o_commit_r;
  logic [LEN_W-1:0]  o_clen_r;
  logic [LCNT_W-1:0] o_evict_r;
  logic [LCNT_W-1:0] o_lines_r;
  logic [BCNT_W-1:0] o_bytes_r;
  logic [LEN_W-1:0]  o_tail_r;
  logic              o_skip_r;
  logic [REV_W-1:0]  o_rev_r;
  logic [LEN_W-1:0]  o_rdata_r;
  logic              o_rvalid_r;

  // Limits
  logic [LL_W-1:0] eff_line_len;
  logic [LC_W-1:0] eff_lines;
  logic [BC_W-1:0] eff_bytes;

  // Memory ports
  logic              ring_we, ring_re;
  logic [BA_W-1:0]   ring_waddr, ring_raddr;
  logic [BYTE_W-1:0] ring_rdata;
  logic              lq_we, lq_re;
  logic [LA_W-1:0]   lq_waddr, lq_raddr;
  logic [LL_W-1:0]   lq_wdata, lq_rdata;

  logic            accept;
  logic            out_free;
  logic            out_load;
  logic [BC_W-1:0] occ;
  logic [BC_W-1:0] ev_len;
  logic            do_consume, do_evict, chk, fin, over, nl_skip_ok;
  logic [LL_W-1:0] len_c;

  bltb_limits #(
    .MAX_BYTES      (MAX_BYTES),
    .MAX_LINES      (MAX_LINES),
    .MAX_LINE_BYTES (MAX_LINE_BYTES)
  ) u_limits (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .eff_line_len (eff_line_len),
    .eff_lines    (eff_lines),
    .eff_bytes    (eff_bytes)
  );

  bltb_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_BYTES)) u_byte_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (data_r),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  bltb_ram #(.WIDTH(LL_W), .DEPTH(MAX_LINES)) u_len_queue (
    .clk   (clk),
    .we    (lq_we),
    .waddr (lq_waddr),
    .wdata (lq_wdata),
    .re    (lq_re),
    .raddr (lq_raddr),
    .rdata (lq_rdata)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Bytes held by complete lines plus the tail line
  assign occ = BC_W'(32'(bytes_r) + 32'(tail_r));

  // Length of the oldest line, never more than what is held
  assign ev_len = (32'(lq_rdata) > 32'(bytes_r)) ? bytes_r : BC_W'(lq_rdata);

  // Read issue. Reads start only in IDLE and EV_RD, and writes land only in DECIDE
  // and COMMIT, so a read never meets a write to the same entry in one cycle.
  always_comb begin
    nl_skip_ok = (in_ch.data_byte == NL_CHAR) && !skip_r && (tail_r != '0);
    ring_re    = 1'b0;
    lq_re      = 1'b0;
    ring_raddr = BA_W'(ring_add(32'(byte_head_r), 32'(occ) - 32'd1, 32'(MAX_BYTES)));
    lq_raddr   = line_head_r;
    if (state_r == ST_IDLE) begin
      if (in_ch.func == FN_READ_BYTE) begin
        ring_raddr = BA_W'(ring_add(32'(byte_head_r), 32'(in_ch.index), 32'(MAX_BYTES)));
        ring_re    = accept && (32'(in_ch.index) < 32'(occ));
      end else if (in_ch.func == FN_CONSUME) begin
        // Last tail byte for the carriage return check; oldest length for a full queue
        ring_re = accept && nl_skip_ok;
        lq_re   = accept;
      end
      if (in_ch.func == FN_READ_LEN) begin
        lq_raddr = LA_W'(ring_add(32'(line_head_r), 32'(in_ch.index), 32'(MAX_LINES)));
        lq_re    = accept && (32'(in_ch.index) < 32'(lines_r));
      end
    end else if (state_r == ST_EV_RD) begin
      lq_re = 1'b1;
    end
  end

  // Sequencer and state update
  always_comb begin
    state_nxt     = state_r;
    byte_head_nxt = byte_head_r;
    line_head_nxt = line_head_r;
    lines_nxt     = lines_r;
    bytes_nxt     = bytes_r;
    tail_nxt      = tail_r;
    skip_nxt      = skip_r;
    rev_nxt       = rev_r;
    commit_nxt    = commit_r;
    clen_nxt      = clen_r;
    evcnt_nxt     = evcnt_r;
    rdata_nxt     = rdata_r;
    rvalid_nxt    = rvalid_r;
    ring_we       = 1'b0;
    ring_waddr    = BA_W'(ring_add(32'(byte_head_r), 32'(occ), 32'(MAX_BYTES)));
    lq_we         = 1'b0;
    lq_waddr      = LA_W'(ring_add(32'(line_head_r), 32'(lines_r), 32'(MAX_LINES)));
    lq_wdata      = '0;
    len_c         = tail_r;
    do_consume    = 1'b0;
    do_evict      = 1'b0;
    chk           = 1'b0;
    fin           = 1'b0;
    out_load      = 1'b0;
    over          = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          commit_nxt = 1'b0;
          clen_nxt   = '0;
          evcnt_nxt  = '0;
          rdata_nxt  = '0;
          rvalid_nxt = 1'b0;
          state_nxt  = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        case (func_r)
          FN_CLEAR: begin
            byte_head_nxt = '0;
            line_head_nxt = '0;
            lines_nxt     = '0;
            bytes_nxt     = '0;
            tail_nxt      = '0;
            skip_nxt      = 1'b0;
            rev_nxt       = rev_r + 1'b1;
            fin           = 1'b1;
          end
          FN_READ_BYTE: begin
            if (32'(idx_r) < 32'(occ)) begin
              rdata_nxt  = RD_W'(ring_rdata);
              rvalid_nxt = 1'b1;
            end
            fin = 1'b1;
          end
          FN_READ_LEN: begin
            if (32'(idx_r) < 32'(lines_r)) begin
              rdata_nxt  = RD_W'(lq_rdata);
              rvalid_nxt = 1'b1;
            end
            fin = 1'b1;
          end
          default: begin
            // A newline into a full queue evicts the oldest line before storing
            if (data_r == NL_CHAR && !skip_r && 32'(lines_r) >= 32'(MAX_LINES)) begin
              do_evict  = 1'b1;
              state_nxt = ST_COMMIT;
            end else begin
              do_consume = 1'b1;
            end
          end
        endcase
      end
      ST_COMMIT: begin
        do_consume = 1'b1;
      end
      ST_EV_RD: begin
        state_nxt = ST_EV_UP;
      end
      ST_EV_UP: begin
        do_evict = 1'b1;
        chk      = 1'b1;
      end
      ST_RESP: begin
        fin = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (do_evict) begin
      byte_head_nxt = BA_W'(ring_add(32'(byte_head_r), 32'(ev_len), 32'(MAX_BYTES)));
      line_head_nxt = LA_W'(ring_add(32'(line_head_r), 32'd1, 32'(MAX_LINES)));
      lines_nxt     = LC_W'(32'(lines_r) - 32'd1);
      bytes_nxt     = bytes_r - ev_len;
      rev_nxt       = rev_r + 1'b1;
      evcnt_nxt     = LC_W'(32'(evcnt_r) + 32'd1);
    end

    if (do_consume) begin
      chk = 1'b1;
      if (data_r == NL_CHAR) begin
        if (!skip_r) begin
          // Strip one carriage return right before the newline
          if (tail_r != '0 && ring_rdata == CR_CHAR) begin
            len_c = LL_W'(32'(tail_r) - 32'd1);
          end
          lq_we      = 1'b1;
          lq_wdata   = len_c;
          lines_nxt  = LC_W'(32'(lines_r) + 32'd1);
          bytes_nxt  = BC_W'(32'(bytes_r) + 32'(len_c));
          commit_nxt = 1'b1;
          clen_nxt   = len_c;
        end
        tail_nxt = '0;
        skip_nxt = 1'b0;
      end else if (!skip_r) begin
        if (32'(tail_r) >= 32'(eff_line_len)) begin
          // Overlong line: drop the tail and skip up to the next newline
          tail_nxt = '0;
          skip_nxt = 1'b1;
          rev_nxt  = rev_r + 1'b1;
        end else begin
          // Store first; a byte landing on the oldest line is covered by eviction below
          ring_we  = 1'b1;
          tail_nxt = LL_W'(32'(tail_r) + 32'd1);
        end
      end
    end

    if (chk) begin
      over = ((32'(lines_nxt) + ((tail_nxt != '0) ? 32'd1 : 32'd0)) > 32'(eff_lines)) ||
             ((32'(bytes_nxt) + 32'(tail_nxt)) > 32'(eff_bytes));
      if (lines_nxt != '0 && over) begin
        state_nxt = ST_EV_RD;
      end else begin
        fin = 1'b1;
      end
    end

    if (fin) begin
      if (out_free) begin
        out_load  = 1'b1;
        state_nxt = ST_IDLE;
      end else begin
        state_nxt = ST_RESP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      byte_head_r <= '0;
      line_head_r <= '0;
      lines_r     <= '0;
      bytes_r     <= '0;
      tail_r      <= '0;
      skip_r      <= 1'b0;
      rev_r       <= '0;
      commit_r    <= 1'b0;
      clen_r      <= '0;
      evcnt_r     <= '0;
      rdata_r     <= '0;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      byte_head_r <= byte_head_nxt;
      line_head_r <= line_head_nxt;
      lines_r     <= lines_nxt;
      bytes_r     <= bytes_nxt;
      tail_r      <= tail_nxt;
      skip_r      <= skip_nxt;
      rev_r       <= rev_nxt;
      commit_r    <= commit_nxt;
      clen_r      <= clen_nxt;
      evcnt_r     <= evcnt_nxt;
      rdata_r     <= rdata_nxt;
      rvalid_r    <= rvalid_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_ch.func;
      data_r <= in_ch.data_byte;
      idx_r  <= in_ch.index;
    end
  end

  // Result capture: the state as it stands after the item
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_commit_r <= commit_nxt;
      o_clen_r   <= LEN_W'(clen_nxt);
      o_evict_r  <= LCNT_W'(evcnt_nxt);
      o_lines_r  <= LCNT_W'(lines_nxt);
      o_bytes_r  <= BCNT_W'(bytes_nxt);
      o_tail_r   <= LEN_W'(tail_nxt);
      o_skip_r   <= skip_nxt;
      o_rev_r    <= rev_nxt;
      o_rdata_r  <= LEN_W'(rdata_nxt);
      o_rvalid_r <= rvalid_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.line_committed   = o_commit_r;
  assign out_ch.committed_length = o_clen_r;
  assign out_ch.evicted_lines    = o_evict_r;
  assign out_ch.line_count       = o_lines_r;
  assign out_ch.retained_bytes   = o_bytes_r;
  assign out_ch.tail_length      = o_tail_r;
  assign out_ch.discarding       = o_skip_r;
  assign out_ch.revision         = o_rev_r;
  assign out_ch.read_data        = o_rdata_r;
  assign out_ch.read_valid       = o_rvalid_r;

endmodule

>>> hw/rtl/bltb_checker.sv
// Port-level checker of the line tail buffer and its bind to the top level.
module bltb_checker import bltb_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              line_committed,
  input logic [LEN_W-1:0]  committed_length,
  input logic [LCNT_W-1:0] line_count,
  input logic [BCNT_W-1:0] retained_bytes,
  input logic [LEN_W-1:0]  tail_length,
  input logic              discarding,
  input logic [REV_W-1:0]  revision
);

  // One item at a time: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is still at work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(line_committed) &&
      $stable(committed_length) && $stable(line_count) && $stable(revision))
    else $error("stalled result changed");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && line_count == '0 |-> retained_bytes == '0)
    else $error("bytes retained without any line");

  a_skip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && discarding |-> tail_length == '0 && !line_committed)
    else $error("tail or commit while discarding");

endmodule

bind bounded_line_tail_buffer_core bltb_checker u_bltb_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .line_committed   (out_ch.line_committed),
  .committed_length (out_ch.committed_length),
  .line_count       (out_ch.line_count),
  .retained_bytes   (out_ch.retained_bytes),
  .tail_length      (out_ch.tail_length),
  .discarding       (out_ch.discarding),
  .revision         (out_ch.revision)
);
